@@ design/u8lcd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8lcd_pkg
// shared types and constants of the polish utf-8 to lcd charset converter
// ----------------------------------------------------------------------------
package u8lcd_pkg;

   localparam logic [1:0] LEAD_NONE = 2'd0;
   localparam logic [1:0] LEAD_C3   = 2'd1;
   localparam logic [1:0] LEAD_C4   = 2'd2;
   localparam logic [1:0] LEAD_C5   = 2'd3;

   localparam logic [7:0] BYTE_C3 = 8'hC3;
   localparam logic [7:0] BYTE_C4 = 8'hC4;
   localparam logic [7:0] BYTE_C5 = 8'hC5;

   localparam logic [7:0] CHAR_QMARK   = 8'h3F;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef struct packed {
      logic       hold;
      logic [1:0] lead;
      logic [7:0] char_code;
   } decode_type;

endpackage

@@ design/u8lcd_map.sv @@
// ----------------------------------------------------------------------------
// u8lcd_map
// decodes one byte against the held lead byte into a display code
// ----------------------------------------------------------------------------
module u8lcd_map
   import u8lcd_pkg::*;
(
   input  logic [7:0]  in_byte,
   input  logic        in_last,
   input  logic [1:0]  pending_lead,
   input  logic        upper_mode,
   output decode_type  result
);

   logic [7:0] pair_char;

   always_comb begin
      pair_char = CHAR_QMARK;
      unique case (pending_lead)
         LEAD_C4: begin
            case (in_byte)
               8'h85:   pair_char = upper_mode ? 8'h41 : 8'h00;
               8'h84:   pair_char = 8'h41;
               8'h87:   pair_char = upper_mode ? 8'h43 : 8'h01;
               8'h86:   pair_char = 8'h43;
               8'h99:   pair_char = upper_mode ? 8'h45 : 8'h02;
               8'h98:   pair_char = 8'h45;
               default: pair_char = CHAR_QMARK;
            endcase
         end
         LEAD_C5: begin
            case (in_byte)
               8'h82:   pair_char = upper_mode ? 8'h4C : 8'h03;
               8'h81:   pair_char = 8'h4C;
               8'h84:   pair_char = upper_mode ? 8'h4E : 8'h04;
               8'h83:   pair_char = 8'h4E;
               8'h9B:   pair_char = upper_mode ? 8'h53 : 8'h06;
               8'h9A:   pair_char = 8'h53;
               8'hBA:   pair_char = upper_mode ? 8'h5A : 8'h7A;
               8'hB9:   pair_char = 8'h5A;
               8'hBC:   pair_char = upper_mode ? 8'h5A : 8'h07;
               8'hBB:   pair_char = 8'h5A;
               default: pair_char = CHAR_QMARK;
            endcase
         end
         LEAD_C3: begin
            case (in_byte)
               8'hB3:   pair_char = upper_mode ? 8'h4F : 8'h05;
               8'h93:   pair_char = 8'h4F;
               default: pair_char = CHAR_QMARK;
            endcase
         end
         LEAD_NONE: pair_char = CHAR_QMARK;
         default:   pair_char = CHAR_QMARK;
      endcase
   end

   always_comb begin
      result.hold      = 1'b0;
      result.lead      = LEAD_NONE;
      result.char_code = in_byte;
      if (pending_lead != LEAD_NONE) begin
         result.char_code = pair_char;
      end else if (in_byte == BYTE_C3 || in_byte == BYTE_C4 || in_byte == BYTE_C5) begin
         result.char_code = CHAR_QMARK;
         if (!in_last) begin
            result.hold = 1'b1;
            if (in_byte == BYTE_C3) begin
               result.lead = LEAD_C3;
            end else if (in_byte == BYTE_C4) begin
               result.lead = LEAD_C4;
            end else begin
               result.lead = LEAD_C5;
            end
         end
      end else if (upper_mode && in_byte >= CHAR_LOWER_A && in_byte <= CHAR_LOWER_Z) begin
         result.char_code = in_byte - CASE_OFFSET;
      end
   end

endmodule

@@ design/utf8_polish_to_lcd_charset.sv @@
// ----------------------------------------------------------------------------
// utf8_polish_to_lcd_charset
// polish utf-8 byte stream to character-lcd code converter
// ----------------------------------------------------------------------------
// One byte per clock in, one display code per decoded character out. Each
// accepted byte lands in an input register; from there the small decode
// table and the held lead byte produce the result into the output register,
// and the block sustains one byte per cycle, stalling only while the output
// register is held by rsp_tready. Lead bytes 0xC3-0xC5 give no beat unless
// they end the string, which gives a '?' beat. A string is cut at
// MAX_LEN-1 characters: that character carries rsp_tlast and the rest of the
// string up to req_tlast is dropped. upper_mode is written through csr_we.
// ----------------------------------------------------------------------------
module utf8_polish_to_lcd_charset
   import u8lcd_pkg::*;
#(
   parameter int MAX_LEN = 64
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_char
   output logic       rsp_tlast    // out_last
);

   localparam int CW = $clog2(MAX_LEN);
   localparam logic [CW-1:0] LIMIT = CW'(MAX_LEN - 1);

   logic          upper_ff, upper_in;
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   logic          in_last_ff, in_last_in;
   logic [1:0]    lead_ff, lead_in;
   logic [CW-1:0] count_ff, count_in;
   logic          trunc_ff, trunc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          out_free;
   logic          advance;
   logic          at_limit;
   logic [CW-1:0] count_inc;
   decode_type    dec;

   u8lcd_map map_i (
      .in_byte      (in_byte_ff),
      .in_last      (in_last_ff),
      .pending_lead (lead_ff),
      .upper_mode   (upper_ff),
      .result       (dec)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign count_inc  = count_ff + 1'b1;
   assign at_limit   = (count_inc == LIMIT);

   always_comb begin
      upper_in     = csr_we ? csr_wdata : upper_ff;
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      lead_in      = lead_ff;
      count_in     = count_ff;
      trunc_in     = trunc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in = 1'b0;
         if (trunc_ff) begin
            if (in_last_ff) begin
               trunc_in = 1'b0;
               count_in = '0;
               lead_in  = LEAD_NONE;
            end
         end else if (dec.hold) begin
            lead_in = dec.lead;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = dec.char_code;
            rsp_last_in  = in_last_ff || at_limit;
            lead_in      = LEAD_NONE;
            if (in_last_ff) begin
               count_in = '0;
            end else begin
               count_in = count_inc;
               trunc_in = at_limit;
            end
         end
      end

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= 1'b0;
         in_valid_ff  <= 1'b0;
         lead_ff      <= LEAD_NONE;
         count_ff     <= '0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upper_ff     <= upper_in;
         in_valid_ff  <= in_valid_in;
         lead_ff      <= lead_in;
         count_ff     <= count_in;
         trunc_ff     <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ design/u8lcd_checker.sv @@
// ----------------------------------------------------------------------------
// u8lcd_checker
// port-level checks of the converter's stream timing
// ----------------------------------------------------------------------------
module u8lcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // a new result follows an accepted input beat
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result beat without a matching input beat");

   // input only backs up behind a stalled result
   a_req_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // result withdrawn only after it was taken
   a_rsp_taken: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_tvalid) |-> $past(rsp_tready))
      else $error("result beat dropped before being taken");

endmodule

bind utf8_polish_to_lcd_charset u8lcd_checker checker_i (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
